### rtl/afc_pkg.sv
// Shared types, constants and arithmetic helpers for the atom distance cutoff filter.
`default_nettype none

package afc_pkg;

    // Number of reference cells in the chain.
    localparam int MAX_REF_ATOMS = 32;

    // Field widths.
    localparam int ACT_W     = 2;
    localparam int COORD_W   = 25;
    localparam int TAG_W     = 16;
    localparam int CUTOFF_W  = 20;
    localparam int LIM_W     = 2 * CUTOFF_W;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 24;

    // Action codes carried on the input tuser.
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TEST  = 2'd2;

    // One item moving down the cell chain, together with the partial
    // distance work that trails it: differences from the previous cell and
    // squares from the cell before that.
    typedef struct packed {
        logic                       vld;
        logic [ACT_W-1:0]           action;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic [TAG_W-1:0]           tag;
        logic                       dv;
        logic signed [DIFF_W-1:0]   dx;
        logic signed [DIFF_W-1:0]   dy;
        logic signed [DIFF_W-1:0]   dz;
        logic                       sv;
        logic [SQ_W-1:0]            sqx;
        logic [SQ_W-1:0]            sqy;
        logic [SQ_W-1:0]            sqz;
        logic                       hit;
    } flow_t;

    // Square of a coordinate difference; the magnitude always fits COORD_W bits.
    function automatic logic [SQ_W-1:0] f_square(input logic signed [DIFF_W-1:0] d);
        logic [COORD_W-1:0] mag;
        logic [DIFF_W-1:0]  neg;
        neg = -d;
        mag = d[DIFF_W-1] ? neg[COORD_W-1:0] : d[COORD_W-1:0];
        return SQ_W'(mag) * SQ_W'(mag);
    endfunction

    // Sum of the three squares compared with the squared cutoff, equality inside.
    function automatic logic f_within(input logic [SQ_W-1:0]  a,
                                      input logic [SQ_W-1:0]  b,
                                      input logic [SQ_W-1:0]  c,
                                      input logic [LIM_W-1:0] lim);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
        return sum <= SUM_W'(lim);
    endfunction

endpackage

`default_nettype wire

### rtl/afc_cell.sv
// One reference cell: holds one reference atom and does one step of distance work per beat.
`default_nettype none

module afc_cell
    import afc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic [LIM_W-1:0] lim,
    input  wire flow_t            flow_in,
    output flow_t                 flow_out
);

    logic                      ref_vld_reg;
    logic                      ref_vld_next;
    logic                      ref_wr;
    logic signed [COORD_W-1:0] ref_x_reg;
    logic signed [COORD_W-1:0] ref_y_reg;
    logic signed [COORD_W-1:0] ref_z_reg;
    flow_t                     flow_reg;
    flow_t                     flow_next;
    logic                      is_clear;
    logic                      is_add;
    logic                      is_test;

    // Decode the item sitting at this cell.
    assign is_clear = flow_in.vld && (flow_in.action == ACT_CLEAR);
    assign is_add   = flow_in.vld && (flow_in.action == ACT_ADD);
    assign is_test  = flow_in.vld && (flow_in.action == ACT_TEST);

    // Own reference work, squares for the previous cell, compare for the one before.
    always_comb begin
        flow_next    = flow_in;
        ref_vld_next = ref_vld_reg;
        ref_wr       = 1'b0;

        if (is_clear) begin
            ref_vld_next = 1'b0;
        end

        // The first empty cell takes an add and turns the beat into a bubble.
        if (is_add && !ref_vld_reg) begin
            ref_vld_next  = 1'b1;
            ref_wr        = 1'b1;
            flow_next.vld = 1'b0;
        end

        flow_next.dv = is_test && ref_vld_reg;
        flow_next.dx = DIFF_W'(flow_in.x) - DIFF_W'(ref_x_reg);
        flow_next.dy = DIFF_W'(flow_in.y) - DIFF_W'(ref_y_reg);
        flow_next.dz = DIFF_W'(flow_in.z) - DIFF_W'(ref_z_reg);

        flow_next.sv  = flow_in.dv;
        flow_next.sqx = f_square(flow_in.dx);
        flow_next.sqy = f_square(flow_in.dy);
        flow_next.sqz = f_square(flow_in.dz);

        flow_next.hit = flow_in.hit
                      | (flow_in.sv & f_within(flow_in.sqx, flow_in.sqy, flow_in.sqz, lim));
    end

    // Control state of the cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_vld_reg  <= 1'b0;
            flow_reg.vld <= 1'b0;
        end else if (en) begin
            ref_vld_reg <= ref_vld_next;
            flow_reg    <= flow_next;
        end
    end

    // Reference coordinates are captured when the cell takes an add and are never cleared.
    always_ff @(posedge aclk) begin
        if (en && ref_wr) begin
            ref_x_reg <= flow_in.x;
            ref_y_reg <= flow_in.y;
            ref_z_reg <= flow_in.z;
        end
    end

    assign flow_out = flow_reg;

endmodule

`default_nettype wire

### rtl/afc_tail.sv
// End of the chain: finishes the last distance checks, keeps the overflow flag, buffers results.
`default_nettype none

module afc_tail
    import afc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [LIM_W-1:0]     lim,
    input  wire flow_t                flow_in,
    output logic                      en,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int RES_W = TAG_W + 2;

    flow_t              stage_reg;
    flow_t              stage_next;
    logic               ovf_reg;
    logic               final_hit;
    logic               push;
    logic               pop;
    logic [RES_W-1:0]   buf_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;

    // The chain moves whenever the result buffer has a free slot.
    assign en = (count_reg != 2'd2);

    // Square the last cell's differences and compare the squares before them.
    always_comb begin
        stage_next     = flow_in;
        stage_next.sv  = flow_in.dv;
        stage_next.sqx = f_square(flow_in.dx);
        stage_next.sqy = f_square(flow_in.dy);
        stage_next.sqz = f_square(flow_in.dz);
        stage_next.hit = flow_in.hit
                       | (flow_in.sv & f_within(flow_in.sqx, flow_in.sqy, flow_in.sqz, lim));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.vld <= 1'b0;
        end else if (en) begin
            stage_reg <= stage_next;
        end
    end

    // Last compare, for the final cell.
    assign final_hit = stage_reg.hit
                     | (stage_reg.sv
                        & f_within(stage_reg.sqx, stage_reg.sqy, stage_reg.sqz, lim));

    // An add that left the chain uncaptured found every cell full.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg <= 1'b0;
        end else if (en && stage_reg.vld) begin
            case (stage_reg.action)
                ACT_CLEAR: ovf_reg <= 1'b0;
                ACT_ADD:   ovf_reg <= 1'b1;
                default:   ovf_reg <= ovf_reg;
            endcase
        end
    end

    // Two-entry result buffer.
    assign push       = en && stage_reg.vld && (stage_reg.action == ACT_TEST);
    assign pop        = m_tvalid && m_tready;
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= {ovf_reg, final_hit, stage_reg.tag};
        end
    end

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, buf_reg[rd_ptr_reg]};

endmodule

`default_nettype wire

### rtl/atom_distance_cutoff_filter.sv
// Top level of the atom distance cutoff filter: cutoff register, cell chain and result tail.
`default_nettype none

// Each beat carries an action in s_tuser: clear the reference set, add a
// reference atom, or test a structure atom. Beats flow through a row of
// MAX_REF_ATOMS reference cells, one cell per cycle while the chain moves;
// adds are taken by the first empty cell, and each test collects a hit bit
// as it passes the filled cells. The block takes one beat every cycle while
// its two-entry result buffer has room, and a test result passes through the
// cell chain, the tail's stage register and the result buffer before it
// appears. Only tests give a result beat: tag, keep flag (squared distance
// at most the squared cutoff to any reference atom) and the sticky overflow
// flag, which is set when an add finds every cell full and is cleared by a
// clear. Write cutoff_distance only while the block is empty.
module atom_distance_cutoff_filter
    import afc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Cutoff distance register.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CUTOFF_W-1:0]   cfg_wr_data,
    // Input beats.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // pos_x[24:0], pos_y[49:25], pos_z[74:50],
                                                 // atom_tag[90:75], zero pad
    input  wire logic [ACT_W-1:0]      s_tuser,  // action[1:0]
    // Result beats.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata   // tag_out[15:0], within_cutoff[16],
                                                 // ref_overflow[17], zero pad
);

    logic [LIM_W-1:0] lim_reg;
    logic             en;
    flow_t            chain [MAX_REF_ATOMS+1];

    // Squared cutoff, formed once per register write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg <= '0;
        end else if (cfg_wr_en) begin
            lim_reg <= LIM_W'(cfg_wr_data) * LIM_W'(cfg_wr_data);
        end
    end

    assign s_tready = en;

    // Head of the chain: the incoming beat with no distance work yet.
    always_comb begin
        chain[0]        = '0;
        chain[0].vld    = s_tvalid;
        chain[0].action = s_tuser;
        chain[0].x      = s_tdata[COORD_W-1:0];
        chain[0].y      = s_tdata[2*COORD_W-1:COORD_W];
        chain[0].z      = s_tdata[3*COORD_W-1:2*COORD_W];
        chain[0].tag    = s_tdata[3*COORD_W+TAG_W-1:3*COORD_W];
    end

    // Row of reference cells.
    for (genvar g = 0; g < MAX_REF_ATOMS; g++) begin : g_cell
        afc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .lim      (lim_reg),
            .flow_in  (chain[g]),
            .flow_out (chain[g+1])
        );
    end

    afc_tail u_tail (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .lim      (lim_reg),
        .flow_in  (chain[MAX_REF_ATOMS]),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### rtl/afc_checker.sv
// Port-level checks for the atom distance cutoff filter and their bind to the top level.
`default_nettype none

module afc_checker
    import afc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tready,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata
);

    // A stalled result beat stays offered.
    a_m_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    // Reset empties the result buffer.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat shown right after reset");

    // With no result pending the block never refuses input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result buffer");

    // Padding bits of the result beat are always zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:TAG_W+2] == '0))
        else $error("nonzero padding in result beat");

endmodule

bind atom_distance_cutoff_filter afc_checker u_afc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
